// ----- sv/mpq_pkg.sv -----
package mpq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 16;
  localparam int PRI_BITS = 31;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENT_W    = KEY_BITS + PRI_BITS;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Result tdata layout, lowest bit first.
  localparam int O_HIT     = 0;
  localparam int O_KEY_LSB = 1;
  localparam int O_PRI_LSB = 17;
  localparam int O_OCC_LSB = 48;
  localparam int O_OCC_W   = 5;

  typedef logic [1:0] func_t;
  localparam func_t FN_PUSH     = 2'd0;
  localparam func_t FN_POP      = 2'd1;
  localparam func_t FN_CONTAINS = 2'd2;
  localparam func_t FN_DEC      = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

endpackage

// ----- sv/min_priority_queue_decrease_key_unit.sv -----
// Min-priority queue with decrease-key, holding up to CAPACITY entries.
// Input channel in_*: in_tuser carries the operation (push, pop minimum,
// contains key, decrease key); in_tdata carries the node key and priority.
// Result channel out_*: exactly one transaction per input transaction, in
// order, with hit, popped key and priority, occupancy in tdata and the
// status code in tuser.
// Entries live in a single-port-write, registered-read memory; valid bits
// and the fill count are flip-flops.
// A push is written at acceptance; its result goes through the response
// state into the output register, and the next transaction can be accepted
// once the result is loaded. Pop, contains and decrease-key sweep the
// memory one slot per cycle (reading slot s while slot s-1 is compared
// and, for decrease-key, written back); after the last slot their result
// goes through the response state into the output register likewise.
// One operation is in flight at a time; a new transaction is accepted
// while the previous result still waits.
// If the receiver stalls, the result is held in the output register and
// the next operation runs, then waits for the output register to empty.
// Synchronous reset clears all valid bits, the count and the handshakes;
// no clearing pass is needed.
module min_priority_queue_decrease_key_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mpq_pkg::IN_TDATA_W-1:0]    in_tdata,   // node_key[15:0], priority_req[46:16]
  input  logic [1:0]                        in_tuser,   // func[1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mpq_pkg::OUT_TDATA_W-1:0]   out_tdata,  // hit[0], out_key[16:1],
                                                        // out_priority[47:17], occupancy[52:48]
  output logic [1:0]                        out_tuser   // status[1:0]
);
  import mpq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [ENT_W-1:0] mem [CAPACITY];
  logic [ENT_W-1:0] rd_data_r;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    scan_r;
  logic                pend_r;
  logic [IDX_W-1:0]    chk_r;
  func_t               op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [PRI_BITS-1:0] pri_r;
  logic                hit_r, found_r;
  logic [IDX_W-1:0]    best_r;
  logic [KEY_BITS-1:0] bkey_r;
  logic [PRI_BITS-1:0] bpri_r;
  status_t             status_r;
  logic [CAPACITY-1:0] valid_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  status_t             out_user_r;

  logic                in_acc, full, proc, last, ent_valid, dec_upd, scan_issue;
  logic                out_free, pop_do, key_eq;
  logic [IDX_W-1:0]    free_idx, mem_wa, mem_ra;
  logic                mem_we;
  logic [ENT_W-1:0]    mem_wd;
  logic [KEY_BITS-1:0] in_key, rd_key;
  logic [PRI_BITS-1:0] in_pri, rd_pri;
  func_t               in_func;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign in_acc  = in_tvalid && in_tready;
  assign in_func = func_t'(in_tuser);
  assign in_key  = KEY_BITS'(in_tdata[15:0]);
  assign in_pri  = in_tdata[46:16];
  assign full    = (count_r == CNT_W'(CAPACITY));

  assign rd_key     = rd_data_r[PRI_BITS +: KEY_BITS];
  assign rd_pri     = rd_data_r[PRI_BITS-1:0];
  assign proc       = pend_r && (state_r == S_SCAN);
  assign last       = proc && (chk_r == IDX_W'(CAPACITY - 1));
  assign ent_valid  = valid_r[chk_r];
  assign key_eq     = (rd_key == key_r);
  assign dec_upd    = proc && (op_r == FN_DEC) && ent_valid && key_eq && (pri_r < rd_pri);
  assign scan_issue = (state_r == S_SCAN) && (scan_r < CNT_W'(CAPACITY));
  assign mem_ra     = scan_r[IDX_W-1:0];
  assign out_free   = !out_valid_r || out_tready;
  assign pop_do     = (op_r == FN_POP) && found_r;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int s = CAPACITY - 1; s >= 0; s--) begin
      if (!valid_r[s]) free_idx = IDX_W'(s);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = free_idx;
    mem_wd = {in_key, in_pri};
    if (in_acc && (in_func == FN_PUSH) && !full) begin
      mem_we = 1'b1;
    end else if (dec_upd) begin
      mem_we = 1'b1;
      mem_wa = chk_r;
      mem_wd = {key_r, pri_r};
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc && (in_func == FN_PUSH) && !full) begin
      count_nxt = count_r + 1'b1;
    end else if ((state_r == S_RESP) && out_free && pop_do) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[O_HIT] = hit_r;
    out_data_nxt[O_KEY_LSB +: 16] = pop_do ? 16'(bkey_r) : 16'd0;
    out_data_nxt[O_PRI_LSB +: PRI_BITS] = pop_do ? bpri_r : '0;
    out_data_nxt[O_OCC_LSB +: O_OCC_W] = O_OCC_W'(count_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = (in_func == FN_PUSH) ? S_RESP : S_SCAN;
      end
      S_SCAN: begin
        if (last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= scan_issue;
      chk_r   <= scan_r[IDX_W-1:0];
      if (scan_issue) scan_r <= scan_r + 1'b1;

      if ((state_r == S_RESP) && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r     <= in_func;
            key_r    <= in_key;
            pri_r    <= in_pri;
            hit_r    <= 1'b0;
            found_r  <= 1'b0;
            scan_r   <= '0;
            status_r <= ((in_func == FN_PUSH) && full) ? STAT_FULL : STAT_OK;
            if ((in_func == FN_PUSH) && !full) valid_r[free_idx] <= 1'b1;
          end
        end
        S_SCAN: begin
          if (proc && ent_valid) begin
            if ((op_r == FN_CONTAINS) && key_eq) hit_r <= 1'b1;
            if (dec_upd) hit_r <= 1'b1;
            // Strict compare keeps the lowest slot on equal priorities.
            if ((op_r == FN_POP) && (!found_r || (rd_pri < bpri_r))) begin
              found_r <= 1'b1;
              best_r  <= chk_r;
              bkey_r  <= rd_key;
              bpri_r  <= rd_pri;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            if (pop_do) valid_r[best_r] <= 1'b0;
            out_data_r <= out_data_nxt;
            out_user_r <= ((op_r == FN_POP) && !found_r) ? STAT_EMPTY : status_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/mpq_checker.sv -----
module mpq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [mpq_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic [1:0]                       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mpq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [1:0]                       out_tuser
);
  import mpq_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A refused push only happens with the queue at capacity.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_FULL) |->
      out_tdata[O_OCC_LSB +: O_OCC_W] == O_OCC_W'(CAPACITY))
    else $error("full status with spare room");

  // A refused pop reports an empty queue and zero payload.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_EMPTY) |->
      (out_tdata[O_OCC_LSB +: O_OCC_W] == '0) && (out_tdata[O_KEY_LSB +: 16] == '0) &&
      (out_tdata[O_PRI_LSB +: PRI_BITS] == '0))
    else $error("empty status with held entries");

  // Refused operations never report a hit.
  a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_OK) |-> !out_tdata[O_HIT])
    else $error("hit on refused operation");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind min_priority_queue_decrease_key_unit mpq_checker u_mpq_checker (.*);

// ----- bench/tb_min_priority_queue_decrease_key_unit.sv -----
`timescale 1ns / 1ps

module tb_min_priority_queue_decrease_key_unit;
  import mpq_pkg::*;

  localparam int RANDOM_OPS  = 1320;
  localparam int IDLE_LIMIT  = 4000;

  typedef struct packed {
    func_t       func;
    logic [15:0] key;
    logic [30:0] pri;
  } op_item_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] key;
    logic [30:0] pri;
    status_t     status;
    logic [4:0]  occ;
  } qres_t;

  typedef struct packed {
    op_item_t   op;
    logic [4:0] reps;
    logic       typed;
    qres_t      want;
  } plan_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = FN_PUSH;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  // Shadow copy of the queue storage.
  logic [15:0]  held_key   [CAPACITY];
  logic [30:0]  held_pri   [CAPACITY];
  logic         held_valid [CAPACITY];
  logic [4:0]   held_count;

  qres_t        pending_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  idle_cycles = 0;
  rx_mode_t     rx_mode = RX_OPEN;
  int unsigned  rx_left = 0;
  logic [31:0]  tick = '0;

  min_priority_queue_decrease_key_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  function automatic qres_t predict_queue_op(input op_item_t it);
    qres_t r;
    logic  found;
    int    best;
    r = '0;
    r.status = STAT_OK;
    found = 1'b0;
    best = 0;
    case (it.func)
      FN_PUSH: begin
        for (int s = 0; s < CAPACITY; s++) begin
          if (!found && !held_valid[s]) begin
            held_valid[s] = 1'b1;
            held_key[s] = it.key;
            held_pri[s] = it.pri;
            held_count = held_count + 5'd1;
            found = 1'b1;
          end
        end
        if (!found) r.status = STAT_FULL;
      end
      FN_POP: begin
        // Strict less-than keeps the lowest slot on a priority tie.
        for (int s = 0; s < CAPACITY; s++) begin
          if (held_valid[s] && (!found || held_pri[s] < held_pri[best])) begin
            best = s;
            found = 1'b1;
          end
        end
        if (found) begin
          r.key = held_key[best];
          r.pri = held_pri[best];
          held_valid[best] = 1'b0;
          held_count = held_count - 5'd1;
        end else begin
          r.status = STAT_EMPTY;
        end
      end
      FN_CONTAINS: begin
        for (int s = 0; s < CAPACITY; s++)
          if (held_valid[s] && held_key[s] == it.key) r.hit = 1'b1;
      end
      default: begin
        for (int s = 0; s < CAPACITY; s++) begin
          if (held_valid[s] && held_key[s] == it.key && it.pri < held_pri[s]) begin
            held_pri[s] = it.pri;
            r.hit = 1'b1;
          end
        end
      end
    endcase
    r.occ = held_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // The sender runs in bursts; before each short burst it drops tvalid for a while.
  task automatic issue_op(input op_item_t it, input logic typed, input qres_t want);
    qres_t predicted;
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(30, 80);
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 24);
      end
    end
    burst_left--;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tdata  <= {1'b0, it.pri, it.key};
    do @(posedge clk); while (!in_tready);
    predicted = predict_queue_op(it);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  // Receiver backpressure: a mode is held for a stretch, then a new one is drawn.
  always @(posedge clk) begin
    tick <= tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
      default:   out_tready <= (tick[2:0] != 3'd0);
    endcase
  end

  always @(posedge clk) begin
    qres_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing pending", out_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[O_HIT] !== want.hit)
          report_mismatch("hit", out_tdata[O_HIT], want.hit);
        if (out_tdata[O_KEY_LSB +: 16] !== want.key)
          report_mismatch("out_key", out_tdata[O_KEY_LSB +: 16], want.key);
        if (out_tdata[O_PRI_LSB +: PRI_BITS] !== want.pri)
          report_mismatch("out_priority", out_tdata[O_PRI_LSB +: PRI_BITS], want.pri);
        if (out_tdata[O_OCC_LSB +: O_OCC_W] !== want.occ)
          report_mismatch("occupancy", out_tdata[O_OCC_LSB +: O_OCC_W], want.occ);
        if (out_tuser !== want.status)
          report_mismatch("status", out_tuser, want.status);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    plan_row_t   plan [17];
    op_item_t    it;
    logic [15:0] key_pool [6];
    logic        filling;
    int unsigned phase_left;
    int unsigned pick;

    for (int s = 0; s < CAPACITY; s++) begin
      held_valid[s] = 1'b0;
      held_key[s] = '0;
      held_pri[s] = '0;
    end
    held_count = '0;

    // Typed rows carry the result directly; the rest rely on the predictor.
    plan[0]  = '{'{FN_POP,      16'h0000, 31'h0},        5'd1,  1'b1,
                 '{1'b0, 16'h0, 31'h0, STAT_EMPTY, 5'd0}};
    plan[1]  = '{'{FN_CONTAINS, 16'h0000, 31'h0},        5'd1,  1'b1,
                 '{1'b0, 16'h0, 31'h0, STAT_OK, 5'd0}};
    plan[2]  = '{'{FN_DEC,      16'hFFFF, 31'h0},        5'd1,  1'b1,
                 '{1'b0, 16'h0, 31'h0, STAT_OK, 5'd0}};
    plan[3]  = '{'{FN_PUSH,     16'hFFFF, 31'h7FFFFFFF}, 5'd1,  1'b1,
                 '{1'b0, 16'h0, 31'h0, STAT_OK, 5'd1}};
    plan[4]  = '{'{FN_PUSH,     16'h0000, 31'h0},        5'd1,  1'b1,
                 '{1'b0, 16'h0, 31'h0, STAT_OK, 5'd2}};
    plan[5]  = '{'{FN_CONTAINS, 16'hFFFF, 31'h0},        5'd1,  1'b1,
                 '{1'b1, 16'h0, 31'h0, STAT_OK, 5'd2}};
    // A decrease to the same priority must leave the entry alone.
    plan[6]  = '{'{FN_DEC,      16'hFFFF, 31'h7FFFFFFF}, 5'd1,  1'b0, '0};
    plan[7]  = '{'{FN_DEC,      16'hFFFF, 31'h7FFFFFFE}, 5'd1,  1'b0, '0};
    plan[8]  = '{'{FN_PUSH,     16'hFFFF, 31'h7FFFFFFE}, 5'd1,  1'b0, '0};
    plan[9]  = '{'{FN_PUSH,     16'h1234, 31'h3},        5'd1,  1'b0, '0};
    // Both copies of the duplicate key drop to a priority shared with another entry.
    plan[10] = '{'{FN_DEC,      16'hFFFF, 31'h3},        5'd1,  1'b0, '0};
    plan[11] = '{'{FN_POP,      16'h0000, 31'h0},        5'd1,  1'b0, '0};
    plan[12] = '{'{FN_POP,      16'h0000, 31'h0},        5'd1,  1'b0, '0};
    plan[13] = '{'{FN_PUSH,     16'hA5A5, 31'h55555555}, 5'd14, 1'b0, '0};
    plan[14] = '{'{FN_PUSH,     16'h5A5A, 31'h2AAAAAAA}, 5'd1,  1'b1,
                 '{1'b0, 16'h0, 31'h0, STAT_FULL, 5'd16}};
    plan[15] = '{'{FN_CONTAINS, 16'h5A5A, 31'h0},        5'd1,  1'b0, '0};
    plan[16] = '{'{FN_DEC,      16'hA5A5, 31'h55555555}, 5'd1,  1'b0, '0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      for (int n = 0; n < plan[i].reps; n++)
        issue_op(plan[i].op, plan[i].typed, plan[i].want);

    for (int k = 0; k < 6; k++) key_pool[k] = 16'($urandom);
    filling = 1'b1;
    phase_left = 0;

    // Alternate push-heavy and pop-heavy stretches so the queue swings
    // between empty and full; a small key pool makes lookups hit often.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (phase_left == 0) begin
        filling = ~filling;
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 50 : 15))
        it.func = FN_PUSH;
      else if (pick < 65)
        it.func = FN_POP;
      else if (pick < 80)
        it.func = FN_CONTAINS;
      else
        it.func = FN_DEC;
      it.key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 5)]
                                          : 16'($urandom);
      it.pri = ($urandom_range(0, 1) == 1) ? 31'($urandom_range(0, 40))
                                           : 31'($urandom);
      issue_op(it, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- min_priority_queue_decrease_key_unit.f -----
sv/mpq_pkg.sv
sv/min_priority_queue_decrease_key_unit.sv
sv/mpq_checker.sv
bench/tb_min_priority_queue_decrease_key_unit.sv
